>>> sv/ps2kbd_pkg.sv
// ----------------------------------------------------------------------------
// ps2kbd_pkg
// Types, command codes and scan code tables of the PS/2 keyboard device side.
// ----------------------------------------------------------------------------
package ps2kbd_pkg;

    localparam int MAKE_BYTES = 8;
    localparam int ROM_KEYS = 125;
    localparam logic [6:0] LAST_REPEAT_KEY = 7'd104;

    typedef enum logic [1:0] {
        FN_HOST = 2'd0,
        FN_KEY  = 2'd1,
        FN_POLL = 2'd2,
        FN_TICK = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        PEND_NONE      = 2'd0,
        PEND_TYPEMATIC = 2'd1,
        PEND_SCANSET   = 2'd2,
        PEND_LEDS      = 2'd3
    } t_pend;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_MAKE  = 2'd1,
        KIND_BREAK = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ROM_PLAIN = 2'd0,
        ROM_EXT   = 2'd1,
        ROM_MAKE  = 2'd2,
        ROM_LONG  = 2'd3
    } t_rom_kind;

    localparam logic CFG_DELAY = 1'b0;
    localparam logic CFG_RATE  = 1'b1;

    localparam logic [7:0] BYTE_ACK     = 8'hFA;
    localparam logic [7:0] BYTE_BAT_OK  = 8'hAA;
    localparam logic [7:0] BYTE_ID0     = 8'hAB;
    localparam logic [7:0] BYTE_ID1     = 8'h83;
    localparam logic [7:0] BYTE_SET2    = 8'h02;
    localparam logic [7:0] BYTE_EXT     = 8'hE0;
    localparam logic [7:0] BYTE_BRK     = 8'hF0;
    localparam logic [7:0] CMD_RESET    = 8'hFF;
    localparam logic [7:0] CMD_RESEND   = 8'hFE;
    localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
    localparam logic [7:0] CMD_DISABLE  = 8'hF5;
    localparam logic [7:0] CMD_ENABLE   = 8'hF4;
    localparam logic [7:0] CMD_TYPEMAT  = 8'hF3;
    localparam logic [7:0] CMD_READ_ID  = 8'hF2;
    localparam logic [7:0] CMD_SCANSET  = 8'hF0;
    localparam logic [7:0] CMD_ECHO     = 8'hEE;
    localparam logic [7:0] CMD_LEDS     = 8'hED;
    localparam logic [7:0] CMD_KT_LO    = 8'hF7;
    localparam logic [7:0] CMD_KT_HI    = 8'hFD;

    typedef struct packed {
        logic [3:0]      len;
        logic [7:0][7:0] b;
    } t_pkt;

    // kind in bits 9:8, scan code in bits 7:0
    localparam logic [9:0] KEY_ROM [ROM_KEYS] = '{
        10'h200, 10'h2FC,
        10'h01C, 10'h032, 10'h021, 10'h023, 10'h024, 10'h02B, 10'h034, 10'h033,
        10'h043, 10'h03B, 10'h042, 10'h04B, 10'h03A,
        10'h031, 10'h044, 10'h04D, 10'h015, 10'h02D, 10'h01B, 10'h02C, 10'h03C,
        10'h02A, 10'h01D, 10'h022, 10'h035, 10'h01A,
        10'h016, 10'h01E, 10'h026, 10'h025, 10'h02E, 10'h036, 10'h03D, 10'h03E,
        10'h046, 10'h045,
        10'h05A, 10'h076, 10'h066, 10'h00D, 10'h029, 10'h04E, 10'h055, 10'h054,
        10'h05B, 10'h05D, 10'h05D, 10'h04C, 10'h052,
        10'h00E, 10'h041, 10'h049, 10'h04A, 10'h058,
        10'h005, 10'h006, 10'h004, 10'h00C, 10'h003, 10'h00B, 10'h083, 10'h00A,
        10'h001, 10'h009, 10'h078, 10'h007,
        10'h17C, 10'h07E, 10'h300, 10'h301, 10'h170, 10'h16C, 10'h17D, 10'h171,
        10'h169,
        10'h17A, 10'h174, 10'h16B, 10'h172, 10'h175,
        10'h077, 10'h14A, 10'h07C, 10'h07B, 10'h079, 10'h15A, 10'h069, 10'h072,
        10'h07A, 10'h06B, 10'h073, 10'h074,
        10'h06C, 10'h075, 10'h07D, 10'h070, 10'h071, 10'h061, 10'h12F, 10'h00F,
        10'h02F, 10'h037, 10'h03F, 10'h06D,
        10'h051, 10'h013, 10'h06A, 10'h064, 10'h067, 10'h027, 10'h2F2, 10'h2F1,
        10'h063, 10'h062, 10'h05F,
        10'h014, 10'h012, 10'h011, 10'h11F, 10'h114, 10'h059, 10'h111, 10'h127
    };

    localparam logic [10:0] DELAY_MS [4] = '{11'd250, 11'd500, 11'd750, 11'd1000};
    localparam logic [9:0] RATE_MS [32] = '{
        10'd33, 10'd37, 10'd42, 10'd46, 10'd48, 10'd54, 10'd58, 10'd62,
        10'd67, 10'd75, 10'd83, 10'd92, 10'd100, 10'd109, 10'd116, 10'd125,
        10'd133, 10'd149, 10'd167, 10'd182, 10'd200, 10'd217, 10'd233, 10'd250,
        10'd270, 10'd303, 10'd333, 10'd370, 10'd400, 10'd435, 10'd476, 10'd500
    };

    function automatic logic [9:0] rom_entry(input logic [6:0] code);
        logic [9:0] e;
        e = 10'h000;
        if (code < 7'(ROM_KEYS)) begin
            e = KEY_ROM[code];
        end
        return e;
    endfunction

    function automatic logic key_repeats(input logic [6:0] code);
        logic [9:0] e;
        e = rom_entry(code);
        return (code <= LAST_REPEAT_KEY) && (code < 7'(ROM_KEYS)) && !e[9];
    endfunction

    function automatic t_pkt build_pkt(input logic [6:0] code, input logic brk);
        t_pkt       p;
        logic [9:0] e;
        logic [7:0] sc;
        p = '0;
        e = rom_entry(code);
        sc = e[7:0];
        if (code < 7'(ROM_KEYS)) begin
            case (t_rom_kind'(e[9:8]))
                ROM_PLAIN: begin
                    if (!brk) begin
                        p.b[0] = sc; p.len = 4'd1;
                    end else begin
                        p.b[0] = BYTE_BRK; p.b[1] = sc; p.len = 4'd2;
                    end
                end
                ROM_EXT: begin
                    p.b[0] = BYTE_EXT;
                    if (!brk) begin
                        p.b[1] = sc; p.len = 4'd2;
                    end else begin
                        p.b[1] = BYTE_BRK; p.b[2] = sc; p.len = 4'd3;
                    end
                end
                ROM_MAKE: begin
                    if (!brk) begin
                        p.b[0] = sc; p.len = 4'd1;
                    end
                end
                default: begin
                    if (!brk) begin
                        if (!sc[0]) begin
                            p.b[0] = 8'hE0; p.b[1] = 8'h7E; p.b[2] = 8'hE0;
                            p.b[3] = 8'hF0; p.b[4] = 8'h7E; p.len = 4'd5;
                        end else begin
                            p.b[0] = 8'hE1; p.b[1] = 8'h14; p.b[2] = 8'h77;
                            p.b[3] = 8'hE1; p.b[4] = 8'hF0; p.b[5] = 8'h14;
                            p.b[6] = 8'hF0; p.b[7] = 8'h77; p.len = 4'd8;
                        end
                    end
                end
            endcase
        end
        return p;
    endfunction

endpackage

>>> sv/ps2_keyboard_device_side.sv
// ----------------------------------------------------------------------------
// ps2_keyboard_device_side
// PS/2 keyboard device side: host command handling, key queue, scan code set 2
// packets and typematic repeat, one beat per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// channel  | dir | fields (lsb first)
// s_*      | in  | func, host_data, host_valid, key_break, key_index, line_busy
// m_*      | out | tx_valid, tx_byte, led_bits, kbd_enabled, key_dropped
// cfg_*    | in  | 0 default_delay_index, 1 default_rate_index
//
// a beat sits in the input register, then one pass of logic updates the state
// and fills the result register: one beat per cycle throughput. a stalled
// result holds the input register, and the input side keeps taking beats
// while the result register drains. reset is synchronous and needs no
// clearing pass.
// ----------------------------------------------------------------------------
module ps2_keyboard_device_side #(
    parameter int KEY_QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // func[1:0] host_data[9:2] host_valid[10] key_break[11] key_index[18:12]
    // line_busy[19]
    input  logic [23:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tx_valid[0] tx_byte[8:1] led_bits[11:9] kbd_enabled[12] key_dropped[13]
    output logic [15:0] o_m_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    localparam int CW = $clog2(KEY_QUEUE_DEPTH + 1);
    localparam int HW = $clog2(KEY_QUEUE_DEPTH);

    logic        r_in_valid;
    logic [19:0] r_in;
    logic        r_out_valid;
    logic [13:0] r_out;
    logic        adv;

    logic [7:0]  r_send_store [ps2kbd_pkg::MAKE_BYTES];
    logic [3:0]  r_send_pos, n_send_pos, r_send_count, n_send_count;
    ps2kbd_pkg::t_pend r_pend, n_pend;
    ps2kbd_pkg::t_kind r_prev_kind, n_prev_kind;
    logic [6:0]  r_prev_key, n_prev_key;
    logic        r_scan_en, n_scan_en;
    logic [1:0]  r_delay_idx, n_delay_idx, r_def_delay;
    logic [4:0]  r_rate_idx, n_rate_idx, r_def_rate;
    logic [2:0]  r_led, n_led;
    logic [7:0]  r_queue [KEY_QUEUE_DEPTH];
    logic [CW-1:0] r_q_count, n_q_count;
    logic [HW-1:0] r_q_head, n_q_head, q_tail;
    logic [CW:0]   tail_sum;
    logic [10:0] r_delay_ms, n_delay_ms;
    logic [9:0]  r_rate_ms, n_rate_ms;

    logic        ld_en;
    ps2kbd_pkg::t_pkt ld_pkt, key_pkt;
    logic        q_wr;
    logic        tx_v;
    logic [7:0]  tx_b;
    logic        dropped;
    logic [7:0]  q_rd;

    ps2kbd_pkg::t_func f_func;
    logic [7:0]  f_data;
    logic        f_valid, f_brk, f_busy;
    logic [6:0]  f_code;

    assign f_func  = ps2kbd_pkg::t_func'(r_in[1:0]);
    assign f_data  = r_in[9:2];
    assign f_valid = r_in[10];
    assign f_brk   = r_in[11];
    assign f_code  = r_in[18:12];
    assign f_busy  = r_in[19];

    assign adv        = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out};

    assign tail_sum = {1'b0, CW'(r_q_head)} + {1'b0, r_q_count};
    assign q_tail = (tail_sum >= (CW+1)'(KEY_QUEUE_DEPTH))
                  ? HW'(tail_sum - (CW+1)'(KEY_QUEUE_DEPTH)) : HW'(tail_sum);
    assign q_rd = r_queue[r_q_head];

    always_comb begin
        n_send_pos   = r_send_pos;
        n_send_count = r_send_count;
        n_pend       = r_pend;
        n_prev_kind  = r_prev_kind;
        n_prev_key   = r_prev_key;
        n_scan_en    = r_scan_en;
        n_delay_idx  = r_delay_idx;
        n_rate_idx   = r_rate_idx;
        n_led        = r_led;
        n_q_count    = r_q_count;
        n_q_head     = r_q_head;
        n_delay_ms   = r_delay_ms;
        n_rate_ms    = r_rate_ms;
        ld_en   = 1'b0;
        ld_pkt  = '0;
        q_wr    = 1'b0;
        tx_v    = 1'b0;
        tx_b    = 8'h00;
        dropped = 1'b0;
        key_pkt = ps2kbd_pkg::build_pkt(q_rd[6:0], q_rd[7]);
        case (f_func)
            ps2kbd_pkg::FN_HOST: begin
                n_send_pos = r_send_count;
                if (f_valid) begin
                    if (r_pend != ps2kbd_pkg::PEND_NONE) begin
                        ld_en = 1'b1;
                        ld_pkt.b[0] = ps2kbd_pkg::BYTE_ACK;
                        ld_pkt.len = 4'd1;
                        if (r_pend == ps2kbd_pkg::PEND_TYPEMATIC) begin
                            n_rate_idx  = f_data[4:0];
                            n_delay_idx = f_data[6:5];
                        end else if (r_pend == ps2kbd_pkg::PEND_SCANSET) begin
                            ld_pkt.b[1] = ps2kbd_pkg::BYTE_SET2;
                            if (f_data == 8'h00) ld_pkt.len = 4'd2;
                        end else begin
                            n_led = f_data[2:0];
                        end
                        n_pend = ps2kbd_pkg::PEND_NONE;
                    end else begin
                        n_q_count = '0;
                        ld_en = 1'b1;
                        ld_pkt.b[0] = ps2kbd_pkg::BYTE_ACK;
                        ld_pkt.len = 4'd1;
                        if (f_data == ps2kbd_pkg::CMD_RESET ||
                            f_data == ps2kbd_pkg::CMD_DEFAULTS) begin
                            n_pend      = ps2kbd_pkg::PEND_NONE;
                            n_prev_kind = ps2kbd_pkg::KIND_NONE;
                            n_scan_en   = 1'b1;
                            n_delay_idx = r_def_delay;
                            n_rate_idx  = r_def_rate;
                            n_led       = 3'b111;
                        end
                        case (f_data) inside
                            ps2kbd_pkg::CMD_RESET: begin
                                ld_pkt.b[1] = ps2kbd_pkg::BYTE_BAT_OK;
                                ld_pkt.len = 4'd2;
                            end
                            ps2kbd_pkg::CMD_RESEND: begin
                                ld_en = 1'b0;
                                n_send_pos = 4'd0;
                            end
                            ps2kbd_pkg::CMD_DEFAULTS: ;
                            ps2kbd_pkg::CMD_DISABLE: n_scan_en = 1'b0;
                            ps2kbd_pkg::CMD_ENABLE:  n_scan_en = 1'b1;
                            ps2kbd_pkg::CMD_TYPEMAT: n_pend = ps2kbd_pkg::PEND_TYPEMATIC;
                            ps2kbd_pkg::CMD_READ_ID: begin
                                ld_pkt.b[1] = ps2kbd_pkg::BYTE_ID0;
                                ld_pkt.b[2] = ps2kbd_pkg::BYTE_ID1;
                                ld_pkt.len = 4'd3;
                            end
                            ps2kbd_pkg::CMD_SCANSET: n_pend = ps2kbd_pkg::PEND_SCANSET;
                            ps2kbd_pkg::CMD_ECHO: ld_pkt.b[0] = ps2kbd_pkg::CMD_ECHO;
                            ps2kbd_pkg::CMD_LEDS: n_pend = ps2kbd_pkg::PEND_LEDS;
                            [ps2kbd_pkg::CMD_KT_LO:ps2kbd_pkg::CMD_KT_HI]: ;
                            default: ld_pkt.b[0] = ps2kbd_pkg::CMD_RESEND;
                        endcase
                    end
                end
            end
            ps2kbd_pkg::FN_KEY: begin
                if (r_q_count >= CW'(KEY_QUEUE_DEPTH)) begin
                    dropped = 1'b1;
                end else begin
                    q_wr = 1'b1;
                    n_q_count = r_q_count + CW'(1);
                end
            end
            ps2kbd_pkg::FN_POLL: begin
                if (f_busy) begin
                    n_rate_ms = '0;
                end else if (r_send_pos < r_send_count) begin
                    tx_v = 1'b1;
                    tx_b = r_send_store[r_send_pos[2:0]];
                    n_send_pos = r_send_pos + 4'd1;
                end else if (r_scan_en && r_pend == ps2kbd_pkg::PEND_NONE) begin
                    if (r_q_count != '0) begin
                        n_q_head = (r_q_head == HW'(KEY_QUEUE_DEPTH - 1))
                                 ? '0 : r_q_head + HW'(1);
                        n_q_count = r_q_count - CW'(1);
                        // an action equal to the last one is swallowed
                        if (!((q_rd[7] ? ps2kbd_pkg::KIND_BREAK : ps2kbd_pkg::KIND_MAKE)
                              == r_prev_kind && q_rd[6:0] == r_prev_key)) begin
                            n_prev_kind = q_rd[7] ? ps2kbd_pkg::KIND_BREAK
                                                  : ps2kbd_pkg::KIND_MAKE;
                            n_prev_key = q_rd[6:0];
                            ld_pkt = key_pkt;
                            ld_en = (key_pkt.len != 4'd0);
                            n_delay_ms = '0;
                        end
                    end else if (r_prev_kind == ps2kbd_pkg::KIND_MAKE &&
                                 ps2kbd_pkg::key_repeats(r_prev_key) &&
                                 r_delay_ms >= ps2kbd_pkg::DELAY_MS[r_delay_idx] &&
                                 r_rate_ms >= ps2kbd_pkg::RATE_MS[r_rate_idx]) begin
                        ld_pkt = ps2kbd_pkg::build_pkt(r_prev_key, 1'b0);
                        ld_en = 1'b1;
                        n_rate_ms = '0;
                    end
                end
            end
            default: begin
                if (r_delay_ms != 11'd2047) n_delay_ms = r_delay_ms + 11'd1;
                if (r_rate_ms != 10'd1023) n_rate_ms = r_rate_ms + 10'd1;
            end
        endcase
        if (ld_en) begin
            n_send_pos = 4'd0;
            n_send_count = ld_pkt.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && ld_en) begin
            for (int i = 0; i < ps2kbd_pkg::MAKE_BYTES; i++) begin
                r_send_store[i] <= ld_pkt.b[i];
            end
        end
        if (adv && q_wr) begin
            r_queue[q_tail] <= {f_brk, f_code};
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in <= i_s_tdata[19:0];
        end
        if (adv) begin
            r_out <= {dropped, n_scan_en, n_led, tx_b, tx_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_send_pos   <= '0;
            r_send_count <= '0;
            r_pend       <= ps2kbd_pkg::PEND_NONE;
            r_prev_kind  <= ps2kbd_pkg::KIND_NONE;
            r_prev_key   <= '0;
            r_scan_en    <= 1'b1;
            r_delay_idx  <= 2'd1;
            r_rate_idx   <= 5'd11;
            r_def_delay  <= 2'd1;
            r_def_rate   <= 5'd11;
            r_led        <= 3'b111;
            r_q_count    <= '0;
            r_q_head     <= '0;
            r_delay_ms   <= '0;
            r_rate_ms    <= '0;
        end else begin
            if (o_s_tready) r_in_valid <= i_s_tvalid;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == ps2kbd_pkg::CFG_DELAY) r_def_delay <= i_cfg_data[1:0];
                else r_def_rate <= i_cfg_data;
            end
            if (adv) begin
                r_send_pos   <= n_send_pos;
                r_send_count <= n_send_count;
                r_pend       <= n_pend;
                r_prev_kind  <= n_prev_kind;
                r_prev_key   <= n_prev_key;
                r_scan_en    <= n_scan_en;
                r_delay_idx  <= n_delay_idx;
                r_rate_idx   <= n_rate_idx;
                r_led        <= n_led;
                r_q_count    <= n_q_count;
                r_q_head     <= n_q_head;
                r_delay_ms   <= n_delay_ms;
                r_rate_ms    <= n_rate_ms;
            end
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_count <= CW'(KEY_QUEUE_DEPTH))
        else $error("key queue over depth");
    a_send_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_send_pos <= r_send_count && r_send_count <= 4'(ps2kbd_pkg::MAKE_BYTES))
        else $error("send pointer out of range");
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out[0] |-> r_out[8:1] == 8'h00)
        else $error("tx byte set without tx valid");
    a_tx_only_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && tx_v |=> r_out[0] && $past(f_func) == ps2kbd_pkg::FN_POLL)
        else $error("byte sent outside a poll");

endmodule
